// File: hw/rtl/intel_hex_record_writer_core_macros.svh
// assertion macros shared by the intel hex record writer rtl
`ifndef INTEL_HEX_RECORD_WRITER_CORE_MACROS_SVH
`define INTEL_HEX_RECORD_WRITER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define IHEX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ihex_pkg.sv
// types, character codes and helper functions of the intel hex record writer
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HDR  = 6'b000010,
        S_DATA = 6'b000100,
        S_SUM  = 6'b001000,
        S_NL   = 6'b010000,
        S_EOF  = 6'b100000
    } t_state;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [3:0] HDR_LAST = 4'd8;
    localparam logic [3:0] EOF_LAST = 4'd11;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    // end-of-file record ":00000001FF" followed by newline
    function automatic logic [7:0] eof_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_COLON;
            4'd8:    c = CH_ONE;
            4'd9:    c = CH_F;
            4'd10:   c = CH_F;
            4'd11:   c = CH_NL;
            default: c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ihex_in_if.sv
// input channel: operation, address and data byte with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface ihex_in_if #(
    parameter int ADDR_BITS = 24
) ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           data_byte;

    modport source (output valid, output operation, output address, output data_byte,
                    input ready);
    modport sink   (input valid, input operation, input address, input data_byte,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ihex_out_if.sv
// output channel: one ascii character per transfer with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface ihex_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ihex_buf.sv
// record data buffer: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module ihex_buf #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [7:0]       i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic [7:0]            o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/ihex_seq.sv
// record sequencer: gathers bytes, emits hex text through a shared checksum adder
`timescale 1ns / 1ps
`default_nettype none
`include "intel_hex_record_writer_core_macros.svh"

module ihex_seq #(
    parameter int RECORD_BYTES = 16,
    parameter int ADDR_BITS    = 24,
    parameter int IDX_W        = 4,
    parameter int CNT_W        = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    ihex_in_if.sink               i_in,
    ihex_out_if.source            o_out,
    output logic                  o_buf_we,
    output logic [IDX_W-1:0]      o_buf_waddr,
    output logic [7:0]            o_buf_wdata,
    output logic [IDX_W-1:0]      o_buf_raddr,
    input  wire logic [7:0]       i_buf_rdata
);
    import ihex_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [ADDR_BITS-1:0] r_start, n_start;
    logic                 r_ov, n_ov;
    logic [7:0]           r_char, n_char;
    logic                 r_last, n_last;
    logic                 r_op, n_op;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [7:0]           r_byte, n_byte;
    logic [3:0]           r_cidx, n_cidx;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_nib, n_nib;
    logic [7:0]           r_sum, n_sum;

    logic                 adv;
    logic                 acc;
    logic                 need_flush;
    logic [ADDR_BITS-1:0] expect_addr;
    logic [7:0]           cnt8;
    logic [15:0]          a16;
    logic [7:0]           csum;
    logic                 emit;
    logic [7:0]           ch;
    logic                 lst;
    logic [7:0]           sum_op;
    logic                 sum_en;

    assign i_in.ready  = (r_state == S_IDLE);
    assign acc         = i_in.valid && i_in.ready;
    assign adv         = !r_ov || o_out.ready;
    assign expect_addr = r_start + ADDR_BITS'(r_fill);
    assign need_flush  = (r_fill != '0) &&
                         ((r_fill >= CNT_W'(RECORD_BYTES)) || (i_in.address != expect_addr));
    assign cnt8        = 8'(r_fill);
    assign a16         = r_start[15:0];
    assign csum        = 8'd0 - r_sum;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_start     = r_start;
        n_op        = r_op;
        n_addr      = r_addr;
        n_byte      = r_byte;
        n_cidx      = r_cidx;
        n_idx       = r_idx;
        n_nib       = r_nib;
        n_sum       = r_sum;
        o_buf_we    = 1'b0;
        o_buf_waddr = r_fill[IDX_W-1:0];
        o_buf_wdata = i_in.data_byte;
        emit        = 1'b0;
        ch          = CH_ZERO;
        lst         = 1'b0;
        sum_op      = '0;
        sum_en      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op   = i_in.operation;
                    n_addr = i_in.address;
                    n_byte = i_in.data_byte;
                    n_cidx = '0;
                    n_idx  = '0;
                    n_nib  = 1'b0;
                    n_sum  = '0;
                    if (i_in.operation == OP_DATA) begin
                        if (need_flush) begin
                            n_state = S_HDR;
                        end else begin
                            o_buf_we = 1'b1;
                            if (r_fill == '0) begin
                                n_start = i_in.address;
                            end
                            n_fill = r_fill + CNT_W'(1);
                        end
                    end else if (r_fill != '0) begin
                        n_state = S_HDR;
                    end else begin
                        n_state = S_EOF;
                    end
                end
            end
            S_HDR: begin
                if (adv) begin
                    emit = 1'b1;
                    case (r_cidx)
                        4'd0: ch = CH_COLON;
                        4'd1: ch = hex_char(cnt8[7:4]);
                        4'd2: begin
                            ch     = hex_char(cnt8[3:0]);
                            sum_en = 1'b1;
                            sum_op = cnt8;
                        end
                        4'd3: ch = hex_char(a16[15:12]);
                        4'd4: begin
                            ch     = hex_char(a16[11:8]);
                            sum_en = 1'b1;
                            sum_op = a16[15:8];
                        end
                        4'd5: ch = hex_char(a16[7:4]);
                        4'd6: begin
                            ch     = hex_char(a16[3:0]);
                            sum_en = 1'b1;
                            sum_op = a16[7:0];
                        end
                        default: ch = CH_ZERO;
                    endcase
                    if (r_cidx == HDR_LAST) begin
                        n_state = S_DATA;
                        n_nib   = 1'b0;
                    end else begin
                        n_cidx = r_cidx + 4'd1;
                    end
                end
            end
            S_DATA: begin
                if (adv) begin
                    emit = 1'b1;
                    if (!r_nib) begin
                        ch    = hex_char(i_buf_rdata[7:4]);
                        n_nib = 1'b1;
                    end else begin
                        ch     = hex_char(i_buf_rdata[3:0]);
                        n_nib  = 1'b0;
                        sum_en = 1'b1;
                        sum_op = i_buf_rdata;
                        if (r_idx + CNT_W'(1) == r_fill) begin
                            n_state = S_SUM;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                end
            end
            S_SUM: begin
                if (adv) begin
                    emit = 1'b1;
                    if (!r_nib) begin
                        ch    = hex_char(csum[7:4]);
                        n_nib = 1'b1;
                    end else begin
                        ch      = hex_char(csum[3:0]);
                        n_nib   = 1'b0;
                        n_state = S_NL;
                    end
                end
            end
            S_NL: begin
                if (adv) begin
                    emit = 1'b1;
                    ch   = CH_NL;
                    if (r_op == OP_DATA) begin
                        lst         = 1'b1;
                        o_buf_we    = 1'b1;
                        o_buf_waddr = '0;
                        o_buf_wdata = r_byte;
                        n_start     = r_addr;
                        n_fill      = CNT_W'(1);
                        n_state     = S_IDLE;
                    end else begin
                        n_fill  = '0;
                        n_cidx  = '0;
                        n_state = S_EOF;
                    end
                end
            end
            S_EOF: begin
                if (adv) begin
                    emit = 1'b1;
                    ch   = eof_char(r_cidx);
                    if (r_cidx == EOF_LAST) begin
                        lst     = 1'b1;
                        n_fill  = '0;
                        n_start = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_cidx = r_cidx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // single checksum adder shared by header and data bytes
        if (sum_en) begin
            n_sum = r_sum + sum_op;
        end
    end

    always_comb begin
        n_ov   = r_ov;
        n_char = r_char;
        n_last = r_last;
        if (emit) begin
            n_ov   = 1'b1;
            n_char = ch;
            n_last = lst;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    // read address is taken from the next index so the registered data matches r_idx
    assign o_buf_raddr = n_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_start <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_start <= n_start;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        r_op   <= n_op;
        r_addr <= n_addr;
        r_byte <= n_byte;
        r_cidx <= n_cidx;
        r_idx  <= n_idx;
        r_nib  <= n_nib;
        r_sum  <= n_sum;
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_last;

    `IHEX_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= CNT_W'(RECORD_BYTES), "fill count over record size")
    `IHEX_ASSERT_IMPL(a_data_idx, r_state == S_DATA, r_idx < r_fill, "data index past fill count")
    `IHEX_ASSERT_NEXT(a_join, acc && (i_in.operation == OP_DATA) && !need_flush, r_fill == CNT_W'($past(r_fill) + CNT_W'(1)), "joining byte did not extend record")
    `IHEX_ASSERT_NEXT(a_eof_clear, (r_state == S_EOF) && (r_cidx == EOF_LAST) && adv, (r_fill == '0) && (r_start == '0) && r_ov && r_last, "end record left state pending")

endmodule

`default_nettype wire

// File: hw/rtl/intel_hex_record_writer_core.sv
// top level of the intel hex record writer
//
//  channel  | dir | payload                               | handshake
//  ---------+-----+---------------------------------------+-------------
//  i_in     | in  | operation, address, data_byte         | valid/ready
//  o_out    | out | out_char, last_char                   | valid/ready
//
// a data byte that joins the pending record is written to the buffer and gives no transfer
// closing a record of n bytes emits 2*n + 12 characters while i_in.ready is low, one
// character per cycle unless o_out stalls, paced by the single character register; an end
// item adds its 12-character record; a stalled o_out holds the sequencer
// synchronous reset empties the pending record; buffer contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_writer_core #(
    parameter int RECORD_BYTES = 16,
    parameter int ADDR_BITS    = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ihex_in_if.sink    i_in,
    ihex_out_if.source o_out
);

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CNT_W = $clog2(RECORD_BYTES + 1);

    logic             buf_we;
    logic [IDX_W-1:0] buf_waddr;
    logic [7:0]       buf_wdata;
    logic [IDX_W-1:0] buf_raddr;
    logic [7:0]       buf_rdata;

    ihex_seq #(
        .RECORD_BYTES (RECORD_BYTES),
        .ADDR_BITS    (ADDR_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_buf_we    (buf_we),
        .o_buf_waddr (buf_waddr),
        .o_buf_wdata (buf_wdata),
        .o_buf_raddr (buf_raddr),
        .i_buf_rdata (buf_rdata)
    );

    ihex_buf #(
        .DEPTH (RECORD_BYTES),
        .IDX_W (IDX_W)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

endmodule

`default_nettype wire
